// ----- design/sscc_pkg.sv -----
package sscc_pkg;

   // Input transaction: one source byte and the end-of-text mark.
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   // Result transaction: one labeled byte.
   typedef struct packed {
      logic [7:0] char_out;
      logic       in_chunk_text;
      logic [1:0] chunk_kind;
      logic       token_char;
      logic       token_end;
      logic       chunk_end;
      logic       text_end;
      logic       chunk_dropped;
   } rsp_type;

   // Byte classes that the chunk logic looks at.
   typedef struct packed {
      logic is_space;
      logic is_newline;
      logic is_slash;
      logic is_star;
      logic is_hash;
      logic is_lbrace;
      logic is_rbrace;
      logic is_semi;
   } char_class_type;

   // One queued byte after classification.
   typedef struct packed {
      logic [7:0]     code;
      logic           last;
      char_class_type cls;
   } queue_entry_type;

   // Queue between the front and the back.
   localparam int QUEUE_ADDR_BITS = 2;
   localparam int QUEUE_DEPTH     = 1 << QUEUE_ADDR_BITS;

   // Chunk kinds.
   localparam logic [1:0] KIND_DIRECTIVE = 2'd0;
   localparam logic [1:0] KIND_COMMENT   = 2'd1;
   localparam logic [1:0] KIND_STATEMENT = 2'd2;
   localparam logic [1:0] KIND_FUNCTION  = 2'd3;

   // Characters of interest.
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;

   // Keywords that keep a statement from becoming a function.
   localparam int KW_COUNT   = 4;
   localparam int KW_STRUCT  = 0;
   localparam int KW_IN      = 1;
   localparam int KW_OUT     = 2;
   localparam int KW_LAYOUT  = 3;
   localparam int KW_SLOTS   = 8;

   // Keyword spelling, zero padded: struct, in, out, layout.
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
      '{8'h73, 8'h74, 8'h72, 8'h75, 8'h63, 8'h74, 8'h00, 8'h00},
      '{8'h69, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6F, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6C, 8'h61, 8'h79, 8'h6F, 8'h75, 8'h74, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd2, 3'd3, 3'd6};

   // Only the layout keyword also matches as a prefix of a longer token.
   localparam logic [KW_COUNT-1:0] KW_PREFIX = 4'b1 << KW_LAYOUT;

   // Sorts one byte into the classes above.
   function automatic char_class_type classify(input logic [7:0] code);
      char_class_type cls;
      cls.is_space   = (code == CHAR_SPACE) || ((code >= CHAR_TAB) && (code <= CHAR_CR));
      cls.is_newline = (code == CHAR_NEWLINE);
      cls.is_slash   = (code == CHAR_SLASH);
      cls.is_star    = (code == CHAR_STAR);
      cls.is_hash    = (code == CHAR_HASH);
      cls.is_lbrace  = (code == CHAR_LBRACE);
      cls.is_rbrace  = (code == CHAR_RBRACE);
      cls.is_semi    = (code == CHAR_SEMI);
      return cls;
   endfunction

endpackage

// ----- design/sscc_front.sv -----
module sscc_front import sscc_pkg::*; (
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   input  logic            queue_full,
   output logic            push,
   output queue_entry_type push_entry
);

   // The input side waits only while the queue has no free slot.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the byte on its way into the queue.
   always_comb begin
      push_entry.code = req_data.char_code;
      push_entry.last = req_data.last_char;
      push_entry.cls  = classify(req_data.char_code);
   end

endmodule

// ----- design/sscc_queue.sv -----
module sscc_queue import sscc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output queue_entry_type head_entry
);

   queue_entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_ADDR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_ADDR_BITS:0]       count_ff, count_in;

   assign full       = (count_ff == (QUEUE_ADDR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/sscc_back.sv -----
module sscc_back import sscc_pkg::*; #(
   parameter int DEPTH_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  queue_entry_type head_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   typedef enum logic [1:0] {PH_MAIN, PH_CLOSE, PH_TAIL, PH_NL} phase_type;

   localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

   phase_type                     phase_ff, phase_in;
   logic [7:0]                    held_code_ff, held_code_in;
   char_class_type                held_cls_ff, held_cls_in;
   logic                          held_valid_ff, held_valid_in;
   logic                          open_ff, open_in;
   logic [1:0]                    kind_ff, kind_in;
   logic                          block_ff, block_in;
   logic signed [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic                          tok_ne_ff, tok_ne_in;
   logic                          ft_done_ff, ft_done_in;
   logic [2:0]                    ft_len_ff, ft_len_in;
   logic [KW_COUNT-1:0]           kw_flags_ff, kw_flags_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic                          advance;
   logic                          do_work;
   logic                          run;
   logic                          emit;
   logic                          close_start;
   logic [7:0]                    cur_code;
   char_class_type                cur_cls;
   logic                          nx_slash;
   logic                          nx_star;
   logic [KW_COUNT-1:0]           kw_keep;
   logic [KW_COUNT-1:0]           kw_long;
   logic                          exempt;
   logic [2:0]                    ft_len_next;
   rsp_type                       res;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The result register moves when it is empty or being taken.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign do_work = head_valid && advance;
   assign run     = do_work && ((phase_ff != PH_MAIN) || held_valid_ff);

   // Pick the byte under work and what follows it.
   always_comb begin
      unique case (phase_ff)
         PH_MAIN, PH_TAIL: begin
            cur_code = held_code_ff;
            cur_cls  = held_cls_ff;
         end
         PH_CLOSE: begin
            cur_code = head_entry.code;
            cur_cls  = head_entry.cls;
         end
         PH_NL: begin
            cur_code = CHAR_NEWLINE;
            cur_cls  = classify(CHAR_NEWLINE);
         end
         default: begin
            cur_code = held_code_ff;
            cur_cls  = held_cls_ff;
         end
      endcase
      nx_slash = (phase_ff == PH_MAIN) && head_entry.cls.is_slash;
      nx_star  = (phase_ff == PH_MAIN) && head_entry.cls.is_star;
   end

   // Keyword tracking of the first token, one compare per keyword.
   always_comb begin
      for (int i = 0; i < KW_COUNT; i++) begin
         kw_keep[i] = (ft_len_ff < KW_LEN[i]) ? (KW_TEXT[i][ft_len_ff] == cur_code)
                                              : KW_PREFIX[i];
         kw_long[i] = (ft_len_ff >= KW_LEN[i]);
      end
      exempt      = ft_done_ff && ((kw_flags_ff & kw_long) != '0);
      ft_len_next = (ft_len_ff == 3'd7) ? ft_len_ff : ft_len_ff + 3'd1;
   end

   // Chunk logic for one step, then the step sequence of a queued byte.
   always_comb begin
      phase_in      = phase_ff;
      held_code_in  = held_code_ff;
      held_cls_in   = held_cls_ff;
      held_valid_in = held_valid_ff;
      open_in       = open_ff;
      kind_in       = kind_ff;
      block_in      = block_ff;
      depth_in      = depth_ff;
      tok_ne_in     = tok_ne_ff;
      ft_done_in    = ft_done_ff;
      ft_len_in     = ft_len_ff;
      kw_flags_in   = kw_flags_ff;
      res           = '0;
      emit          = 1'b0;
      close_start   = 1'b0;
      pop           = 1'b0;

      if (run) begin
         emit         = 1'b1;
         res.char_out = cur_code;
         if (phase_ff == PH_CLOSE) begin
            // Closing slash of a block comment ends the chunk.
            res.in_chunk_text = 1'b1;
            res.token_char    = 1'b1;
            res.token_end     = 1'b1;
            res.chunk_end     = 1'b1;
            open_in           = 1'b0;
         end else if (!open_ff) begin
            if (!cur_cls.is_space) begin
               // A non-space byte opens a chunk; the kind comes from it and the byte after it.
               open_in  = 1'b1;
               block_in = 1'b0;
               if (cur_cls.is_slash && nx_slash) begin
                  kind_in = KIND_COMMENT;
               end else if (cur_cls.is_slash && nx_star) begin
                  kind_in  = KIND_COMMENT;
                  block_in = 1'b1;
               end else if (cur_cls.is_hash) begin
                  kind_in = KIND_DIRECTIVE;
               end else begin
                  kind_in = KIND_STATEMENT;
               end
               tok_ne_in = 1'b1;
               if (!ft_done_ff) begin
                  kw_flags_in = kw_flags_ff & kw_keep;
                  ft_len_in   = ft_len_next;
               end
               res.in_chunk_text = 1'b1;
               res.token_char    = 1'b1;
            end
         end else if (cur_cls.is_newline && ((kind_ff == KIND_DIRECTIVE) ||
                      ((kind_ff == KIND_COMMENT) && !block_ff))) begin
            // Newline ends a directive or a line comment.
            res.token_end = tok_ne_ff;
            res.chunk_end = 1'b1;
            open_in       = 1'b0;
         end else if (((kind_ff == KIND_STATEMENT) && cur_cls.is_semi &&
                       (depth_ff == '0)) ||
                      ((kind_ff == KIND_FUNCTION) && cur_cls.is_rbrace &&
                       (depth_ff == DEPTH_ONE))) begin
            // Semicolon at top level or the final closing brace.
            if (kind_ff == KIND_FUNCTION) begin
               depth_in = depth_ff - DEPTH_ONE;
            end
            res.in_chunk_text = 1'b1;
            res.token_char    = 1'b1;
            res.token_end     = 1'b1;
            res.chunk_end     = 1'b1;
            open_in           = 1'b0;
         end else if ((kind_ff == KIND_COMMENT) && block_ff && cur_cls.is_star &&
                      nx_slash) begin
            // Star of the block comment close; the slash follows next step.
            close_start = 1'b1;
            tok_ne_in   = 1'b1;
            if (!ft_done_ff) begin
               kw_flags_in = kw_flags_ff & kw_keep;
               ft_len_in   = ft_len_next;
            end
            res.in_chunk_text = 1'b1;
            res.token_char    = 1'b1;
         end else begin
            // Plain byte inside a chunk.
            if (cur_cls.is_space) begin
               tok_ne_in     = 1'b0;
               ft_done_in    = ft_done_ff || tok_ne_ff;
               res.token_end = tok_ne_ff;
            end else begin
               tok_ne_in = 1'b1;
               if (!ft_done_ff) begin
                  kw_flags_in = kw_flags_ff & kw_keep;
                  ft_len_in   = ft_len_next;
               end
            end
            if (cur_cls.is_lbrace) begin
               depth_in = (depth_ff == DEPTH_MAX) ? depth_ff : depth_ff + DEPTH_ONE;
               if ((kind_ff == KIND_STATEMENT) && !exempt) begin
                  kind_in = KIND_FUNCTION;
               end
            end else if (cur_cls.is_rbrace) begin
               depth_in = (depth_ff == DEPTH_MIN) ? depth_ff : depth_ff - DEPTH_ONE;
            end
            res.in_chunk_text = 1'b1;
            res.token_char    = !cur_cls.is_space;
         end

         // A chunk that ends clears the token tracking.
         if (open_ff && !open_in) begin
            tok_ne_in   = 1'b0;
            ft_done_in  = 1'b0;
            ft_len_in   = '0;
            kw_flags_in = '1;
            block_in    = 1'b0;
         end
         res.chunk_kind = kind_in;
      end

      // Step sequence for the byte at the queue head.
      if (do_work) begin
         unique case (phase_ff)
            PH_MAIN: begin
               if (close_start) begin
                  phase_in = PH_CLOSE;
               end else begin
                  held_code_in  = head_entry.code;
                  held_cls_in   = head_entry.cls;
                  held_valid_in = 1'b1;
                  if (head_entry.last) begin
                     phase_in = PH_TAIL;
                  end else begin
                     pop = 1'b1;
                  end
               end
            end
            PH_CLOSE: begin
               held_valid_in = 1'b0;
               if (head_entry.last) begin
                  phase_in = PH_NL;
               end else begin
                  phase_in = PH_MAIN;
                  pop      = 1'b1;
               end
            end
            PH_TAIL: begin
               held_valid_in = 1'b0;
               phase_in      = PH_NL;
            end
            PH_NL: begin
               // Appended newline ends the text; all state returns to reset.
               res.text_end      = 1'b1;
               res.chunk_dropped = open_in;
               pop               = 1'b1;
               phase_in          = PH_MAIN;
               held_code_in      = '0;
               held_valid_in     = 1'b0;
               open_in           = 1'b0;
               kind_in           = KIND_DIRECTIVE;
               block_in          = 1'b0;
               depth_in          = '0;
               tok_ne_in         = 1'b0;
               ft_done_in        = 1'b0;
               ft_len_in         = '0;
               kw_flags_in       = '1;
            end
            default: begin
               phase_in = PH_MAIN;
            end
         endcase
      end

      rsp_valid_in = advance ? emit : rsp_valid_ff;
      rsp_data_in  = (advance && emit) ? res : rsp_data_ff;
   end

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAIN;
         held_code_ff  <= '0;
         held_valid_ff <= 1'b0;
         open_ff       <= 1'b0;
         kind_ff       <= KIND_DIRECTIVE;
         block_ff      <= 1'b0;
         depth_ff      <= '0;
         tok_ne_ff     <= 1'b0;
         ft_done_ff    <= 1'b0;
         ft_len_ff     <= '0;
         kw_flags_ff   <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         held_code_ff  <= held_code_in;
         held_valid_ff <= held_valid_in;
         open_ff       <= open_in;
         kind_ff       <= kind_in;
         block_ff      <= block_in;
         depth_ff      <= depth_in;
         tok_ne_ff     <= tok_ne_in;
         ft_done_ff    <= ft_done_in;
         ft_len_ff     <= ft_len_in;
         kw_flags_ff   <= kw_flags_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      held_cls_ff <= held_cls_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- design/shader_source_chunk_classifier.sv -----
// A byte is labeled once the byte after it has arrived: its result is registered as that
// next byte reaches the queue head. Throughput is one byte per cycle without output stalls;
// a block comment close adds a step for its slash, and the last byte of a text goes through
// tail and newline steps. Rate is set by the back end, at most one result per cycle.
// Reset is synchronous and clears the queue, the held byte and all chunk state at once.
module shader_source_chunk_classifier import sscc_pkg::*; #(
   parameter int DEPTH_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic            queue_full;
   logic            push;
   queue_entry_type push_entry;
   logic            pop;
   logic            head_valid;
   queue_entry_type head_entry;

   // Front: accepts and classifies each transaction.
   sscc_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Short queue that lets the two halves stall independently.
   sscc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back: chunk and token tracking and the result register.
   sscc_back #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
